FILE: hw/rtl/table_geo_point_distance_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the table_geo_point_distance block
// Implication checks, with and without the reset qualifier.
// ---------------------------------------------------------------------------
`ifndef TABLE_GEO_POINT_DISTANCE_MACROS_SVH
`define TABLE_GEO_POINT_DISTANCE_MACROS_SVH

`ifndef SYNTHESIS
`define TGPD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tgpd assertion failed");
`define TGPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tgpd assertion failed");
`else
`define TGPD_ASSERT_IMPL(label, ante, cons)
`define TGPD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: hw/rtl/tgpd_pkg.sv
// ---------------------------------------------------------------------------
// tgpd_pkg
// Constants, widths and degree-length tables of the point distance block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgpd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 23;
  localparam int SUM_W     = COORD_W + 1;
  localparam int FB1       = FRAC_BITS + 1;
  localparam int IDX_W     = SUM_W - FB1;
  localparam int TAB_W     = 11;
  localparam int LEN_W     = TAB_W + FB1;
  localparam int LEG_FRAC  = 6;
  localparam int LEG_W     = 32;
  localparam int SQ_W      = 2 * LEG_W;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int DIST_W    = 24;
  localparam int LEG_SHR   = 2 * FRAC_BITS + 1 - LEG_FRAC - 2;
  localparam int LAT_LAST  = 90;
  localparam int LON_LAST  = 89;

  localparam logic [TAB_W-1:0] LAT_TAB [91] = '{
    11'd1113, 11'd1113, 11'd1113, 11'd1112, 11'd1111, 11'd1109, 11'd1107, 11'd1105,
    11'd1102, 11'd1100, 11'd1096, 11'd1093, 11'd1089, 11'd1085, 11'd1080, 11'd1076,
    11'd1070, 11'd1065, 11'd1059, 11'd1053, 11'd1046, 11'd1040, 11'd1033, 11'd1025,
    11'd1018, 11'd1010, 11'd1001, 11'd993,  11'd984,  11'd974,  11'd965,  11'd955,
    11'd945,  11'd935,  11'd924,  11'd913,  11'd902,  11'd890,  11'd878,  11'd866,
    11'd854,  11'd841,  11'd829,  11'd815,  11'd802,  11'd788,  11'd775,  11'd761,
    11'd746,  11'd732,  11'd717,  11'd702,  11'd687,  11'd671,  11'd656,  11'd640,
    11'd624,  11'd608,  11'd591,  11'd575,  11'd558,  11'd541,  11'd524,  11'd507,
    11'd489,  11'd472,  11'd454,  11'd436,  11'd418,  11'd400,  11'd382,  11'd364,
    11'd345,  11'd326,  11'd308,  11'd289,  11'd270,  11'd251,  11'd232,  11'd213,
    11'd194,  11'd175,  11'd155,  11'd136,  11'd117,  11'd97,   11'd78,   11'd58,
    11'd39,   11'd19,   11'd0
  };

  localparam logic [TAB_W-1:0] LON_TAB [90] = '{
    11'd1106, 11'd1106, 11'd1106, 11'd1106, 11'd1106, 11'd1106, 11'd1106, 11'd1106,
    11'd1106, 11'd1106, 11'd1106, 11'd1106, 11'd1106, 11'd1106, 11'd1106, 11'd1107,
    11'd1107, 11'd1107, 11'd1107, 11'd1107, 11'd1107, 11'd1107, 11'd1107, 11'd1108,
    11'd1108, 11'd1108, 11'd1108, 11'd1108, 11'd1108, 11'd1108, 11'd1109, 11'd1109,
    11'd1109, 11'd1109, 11'd1109, 11'd1110, 11'd1110, 11'd1110, 11'd1110, 11'd1110,
    11'd1110, 11'd1111, 11'd1111, 11'd1111, 11'd1111, 11'd1111, 11'd1112, 11'd1112,
    11'd1112, 11'd1112, 11'd1112, 11'd1113, 11'd1113, 11'd1113, 11'd1113, 11'd1113,
    11'd1114, 11'd1114, 11'd1114, 11'd1114, 11'd1114, 11'd1114, 11'd1115, 11'd1115,
    11'd1115, 11'd1115, 11'd1115, 11'd1115, 11'd1115, 11'd1116, 11'd1116, 11'd1116,
    11'd1116, 11'd1116, 11'd1116, 11'd1116, 11'd1116, 11'd1116, 11'd1117, 11'd1117,
    11'd1117, 11'd1117, 11'd1117, 11'd1117, 11'd1117, 11'd1117, 11'd1117, 11'd1117,
    11'd1117, 11'd1117
  };

  // Past the last entry every latitude reads as zero length.
  function automatic logic [TAB_W-1:0] lat_len(input logic [IDX_W:0] idx);
    logic [TAB_W-1:0] v;
    v = '0;
    if (idx <= (IDX_W+1)'(LAT_LAST)) begin
      v = LAT_TAB[idx[IDX_W-1:0]];
    end
    return v;
  endfunction

  // Indexes beyond the last entry clamp to it.
  function automatic logic [TAB_W-1:0] lon_len(input logic [IDX_W:0] idx);
    logic [TAB_W-1:0] v;
    v = LON_TAB[LON_LAST];
    if (idx < (IDX_W+1)'(LON_LAST)) begin
      v = LON_TAB[idx[IDX_W-1:0]];
    end
    return v;
  endfunction

endpackage

FILE: hw/rtl/tgpd_len.sv
// ---------------------------------------------------------------------------
// tgpd_len
// Table lookup and linear interpolation of both degree lengths, two stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgpd_len
  import tgpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  logic [SUM_W-1:0] lat_sum,
  input  logic [SUM_W-1:0] lon_sum,
  output logic             out_v,
  output logic [LEN_W-1:0] len_ew,
  output logic [LEN_W-1:0] len_ns
);

  logic [1:0]       v_r;
  logic [TAB_W-1:0] ew_t0_r, ew_t1_r, ns_t0_r, ns_t1_r;
  logic [FB1-1:0]   ew_f_r, ns_f_r;
  logic [LEN_W-1:0] len_ew_r, len_ns_r;
  logic [IDX_W:0]   ew_idx, ns_idx;

  assign ew_idx = {1'b0, lat_sum[SUM_W-1:FB1]};
  assign ns_idx = {1'b0, lon_sum[SUM_W-1:FB1]};

  function automatic logic [LEN_W-1:0] interp(input logic [TAB_W-1:0] t0,
                                              input logic [TAB_W-1:0] t1,
                                              input logic [FB1-1:0] f);
    logic signed [TAB_W+1:0]       dlt;
    logic signed [TAB_W+FB1+2:0]   acc;
    dlt = $signed({2'b00, t1}) - $signed({2'b00, t0});
    acc = $signed({3'b000, t0, {FB1{1'b0}}}) + dlt * $signed({1'b0, f});
    return acc[LEN_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ew_t0_r  <= lat_len(ew_idx);
      ew_t1_r  <= lat_len(ew_idx + 1'b1);
      ns_t0_r  <= lon_len(ns_idx);
      ns_t1_r  <= lon_len(ns_idx + 1'b1);
      ew_f_r   <= lat_sum[FB1-1:0];
      ns_f_r   <= lon_sum[FB1-1:0];
      len_ew_r <= interp(ew_t0_r, ew_t1_r, ew_f_r);
      len_ns_r <= interp(ns_t0_r, ns_t1_r, ns_f_r);
    end
  end

  assign out_v  = v_r[1];
  assign len_ew = len_ew_r;
  assign len_ns = len_ns_r;

endmodule

FILE: hw/rtl/tgpd_leg.sv
// ---------------------------------------------------------------------------
// tgpd_leg
// One leg: coordinate difference times degree length, scaled to metres
// with six fraction bits and capped, in three stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgpd_leg
  import tgpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  logic [COORD_W-1:0] diff,
  input  logic [LEN_W-1:0]   len,
  output logic               out_v,
  output logic [LEG_W-1:0]   leg
);

  localparam int LO_W   = 12;
  localparam int HI_W   = COORD_W - LO_W;
  localparam int PROD_W = COORD_W + LEN_W;
  localparam int SCL_W  = PROD_W + 5;
  localparam logic [SCL_W-1:0] LEG_CAP = SCL_W'(64'd1 << (25 + LEG_FRAC));

  logic [2:0]             v_r;
  logic [LO_W+LEN_W-1:0]  p_lo_r;
  logic [HI_W+LEN_W-1:0]  p_hi_r;
  logic [PROD_W-1:0]      prod_r;
  logic [LEG_W-1:0]       leg_r;
  logic [SCL_W-1:0]       scl, shr;

  // Times 25 as 16 + 8 + 1.
  assign scl = ({5'b0, prod_r} << 4) + ({5'b0, prod_r} << 3) + {5'b0, prod_r};
  assign shr = scl >> LEG_SHR;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo_r <= diff[LO_W-1:0] * len;
      p_hi_r <= diff[COORD_W-1:LO_W] * len;
      prod_r <= PROD_W'(p_lo_r) + (PROD_W'(p_hi_r) << LO_W);
      leg_r  <= (shr > LEG_CAP) ? LEG_CAP[LEG_W-1:0] : shr[LEG_W-1:0];
    end
  end

  assign out_v = v_r[2];
  assign leg   = leg_r;

endmodule

FILE: hw/rtl/tgpd_sqrt.sv
// ---------------------------------------------------------------------------
// tgpd_sqrt
// Sum of squared legs, then a pipelined digit-by-digit integer square root
// that settles one root bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgpd_sqrt
  import tgpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [LEG_W-1:0]  leg_ew,
  input  logic [LEG_W-1:0]  leg_ns,
  output logic              out_v,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 2;

  logic [1:0]       pv_r;
  logic [SQ_W-1:0]  sq_ew_r, sq_ns_r, sum_r;

  logic [ROOT_W:0]  v_r;
  logic [SQ_W-1:0]  x_r    [ROOT_W+1];
  logic [REM_W-1:0] rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0] root_r [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (en) begin
      pv_r <= {pv_r[0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_ew_r <= leg_ew * leg_ew;
      sq_ns_r <= leg_ns * leg_ns;
      sum_r   <= sq_ew_r + sq_ns_r;
    end
  end

  assign v_r[0]    = pv_r[1];
  assign x_r[0]    = sum_r;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W-1:0] rem_sh, trial;
    assign rem_sh = {rem_r[k][REM_W-3:0], x_r[k][SQ_W-1:SQ_W-2]};
    assign trial  = {root_r[k], 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k+1] <= {x_r[k][SQ_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r[k+1]  <= rem_sh - trial;
          root_r[k+1] <= {root_r[k][ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[k+1]  <= rem_sh;
          root_r[k+1] <= {root_r[k][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_v = v_r[ROOT_W];
  assign root  = root_r[ROOT_W];

endmodule

FILE: hw/rtl/table_geo_point_distance.sv
// Approximate distance between two points in the 0 to 90 degree quadrant.
// Input channel in_*: one transaction carries both points (longitude and
// latitude, degrees with 16 fraction bits). Output channel out_*: one
// transaction per input carries the distance in whole metres, floored and
// saturated at 24 bits.
// From input acceptance to output valid the pipeline runs through one stage for
// sums and differences, two for table interpolation, three for the leg
// multiply and scale, two for squaring and summing, 32 for the square root
// (one result bit per stage) and one output register.
// Throughput is one transaction per cycle while the receiver does not stall;
// the pipeline holds up to 41 items in flight.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; no clearing pass is needed, and the block
// keeps no state between items.
// ---------------------------------------------------------------------------
// table_geo_point_distance
// Top level: coordinate front end, pipeline control and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "table_geo_point_distance_macros.svh"

module table_geo_point_distance
  import tgpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // lon_a[22:0], lat_a[45:23], lon_b[68:46], lat_b[91:69]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // distance_m[23:0]
);

  logic               en;
  logic [COORD_W-1:0] lon_a, lat_a, lon_b, lat_b;

  logic               s1_v_r;
  logic [SUM_W-1:0]   lat_sum_r, lon_sum_r;
  logic [COORD_W-1:0] dlon_r, dlat_r, dlon_d_r, dlat_d_r, dlon_e_r, dlat_e_r;

  logic               len_v, leg_v, leg_ns_v, root_v;
  logic [LEN_W-1:0]   len_ew, len_ns;
  logic [LEG_W-1:0]   leg_ew, leg_ns;
  logic [ROOT_W-1:0]  root;
  logic [ROOT_W-1:0]  dist_full;

  logic               out_v_r;
  logic [DIST_W-1:0]  dist_r;

  // The pipeline moves as one; it holds only while a result waits.
  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  assign lon_a = in_tdata[22:0];
  assign lat_a = in_tdata[45:23];
  assign lon_b = in_tdata[68:46];
  assign lat_b = in_tdata[91:69];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat_sum_r <= {1'b0, lat_a} + {1'b0, lat_b};
      lon_sum_r <= {1'b0, lon_a} + {1'b0, lon_b};
      dlon_r    <= (lon_a > lon_b) ? lon_a - lon_b : lon_b - lon_a;
      dlat_r    <= (lat_a > lat_b) ? lat_a - lat_b : lat_b - lat_a;
      // Differences wait out the two interpolation stages.
      dlon_d_r  <= dlon_r;
      dlat_d_r  <= dlat_r;
      dlon_e_r  <= dlon_d_r;
      dlat_e_r  <= dlat_d_r;
    end
  end

  tgpd_len u_len (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (s1_v_r),
    .lat_sum (lat_sum_r),
    .lon_sum (lon_sum_r),
    .out_v   (len_v),
    .len_ew  (len_ew),
    .len_ns  (len_ns)
  );

  tgpd_leg u_leg_ew (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (len_v),
    .diff  (dlon_e_r),
    .len   (len_ew),
    .out_v (leg_v),
    .leg   (leg_ew)
  );

  tgpd_leg u_leg_ns (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (len_v),
    .diff  (dlat_e_r),
    .len   (len_ns),
    .out_v (leg_ns_v),
    .leg   (leg_ns)
  );

  tgpd_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (leg_v),
    .leg_ew (leg_ew),
    .leg_ns (leg_ns),
    .out_v  (root_v),
    .root   (root)
  );

  assign dist_full = root >> LEG_FRAC;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= root_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= (dist_full > ROOT_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
                                                       : dist_full[DIST_W-1:0];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = dist_r;

  `TGPD_ASSERT_NEXT(a_reset_clears_out, !rst_n, !out_tvalid)
  `TGPD_ASSERT_IMPL(a_legs_in_step, len_v || leg_v, leg_v == leg_ns_v)
  `TGPD_ASSERT_IMPL(a_hold_when_stalled, out_tvalid && !out_tready, !in_tready)

endmodule

FILE: tb/table_geo_point_distance_tb.sv
// ---------------------------------------------------------------------------
// table_geo_point_distance_tb
// Drives point pairs into the distance block and compares each distance
// against a bit-exact integer predictor, with random stalls on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module table_geo_point_distance_tb;
  import tgpd_pkg::*;

  localparam int COORD_MAX = 5898240;
  localparam int LON_MAX   = 5898239;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;   // lon_a[22:0], lat_a[45:23], lon_b[68:46], lat_b[91:69]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // distance_m[23:0]

  logic [23:0] expected_dist[$];
  int          errors = 0;
  bit          calm = 1'b0;

  always #1 clk = ~clk;

  table_geo_point_distance DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  function automatic longint unsigned degree_length(input longint unsigned sum,
                                                    input bit by_lat);
    longint unsigned idx, frac, one, t0, t1, last;
    one  = 64'd1 << FB1;
    idx  = sum >> FB1;
    frac = sum & (one - 1);
    last = by_lat ? LAT_LAST : LON_LAST;
    if (idx >= last) begin
      t0 = by_lat ? LAT_TAB[LAT_LAST] : LON_TAB[LON_LAST];
      t1 = t0;
    end else begin
      t0 = by_lat ? LAT_TAB[idx] : LON_TAB[idx];
      t1 = by_lat ? LAT_TAB[idx+1] : LON_TAB[idx+1];
    end
    return t0 * (one - frac) + t1 * frac;
  endfunction

  function automatic longint unsigned leg_length(input longint unsigned a,
                                                 input longint unsigned b,
                                                 input longint unsigned len);
    longint unsigned d, v;
    d = (a > b) ? a - b : b - a;
    v = ((d * len) * 25) >> LEG_SHR;
    return (v > (64'd1 << 31)) ? (64'd1 << 31) : v;
  endfunction

  function automatic logic [23:0] point_distance(input logic [22:0] lon_a, lat_a,
                                                 lon_b, lat_b);
    longint unsigned ew, ns, x, r, b;
    ew = leg_length(lon_a, lon_b, degree_length(lat_a + lat_b, 1'b1));
    ns = leg_length(lat_a, lat_b, degree_length(lon_a + lon_b, 1'b0));
    x = ew * ew + ns * ns;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    r >>= LEG_FRAC;
    return (r > 64'hFFFFFF) ? 24'hFFFFFF : r[23:0];
  endfunction

  // Only the low 23 bits of each coordinate travel.
  task automatic send_points(input int unsigned lon_a, lat_a, lon_b, lat_b);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, lat_b[22:0], lon_b[22:0], lat_a[22:0], lon_a[22:0]};
    expected_dist.push_back(point_distance(lon_a[22:0], lat_a[22:0],
                                           lon_b[22:0], lat_b[22:0]));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver stalls in bursts.
  always @(negedge clk) begin
    if (calm || !rst_n) begin
      out_tready <= rst_n;
    end else if ($urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_dist.size() == 0) begin
        $display("%0t: unexpected distance %0d", $time, out_tdata);
        errors++;
      end else begin
        if (out_tdata !== expected_dist[0]) begin
          $display("%0t: distance expected %0d actual %0d", $time,
                   expected_dist[0], out_tdata);
          errors++;
        end
        void'(expected_dist.pop_front());
      end
    end
  end

  task automatic test_extremes();
    send_points(0, 0, 0, 0);
    send_points(LON_MAX, COORD_MAX, 0, 0);
    send_points(0, 0, LON_MAX, COORD_MAX);
    send_points(LON_MAX, COORD_MAX, LON_MAX, COORD_MAX);
    send_points(0, COORD_MAX, LON_MAX, COORD_MAX);   // east-west leg vanishes
    send_points(LON_MAX, 0, LON_MAX, COORD_MAX);     // longitude table clamp
    send_points(89 << 16, 0, 89 << 16, 90 << 16);
    send_points(0, 45 << 16, 1 << 16, 45 << 16);
    send_points(12345, 67890, 12346, 67891);
    send_points('h7FFFFF, 'h7FFFFF, 0, 0);           // out of range, huge legs
    send_points(0, 0, 'h7FFFFF, 'h7FFFFF);
    send_points('h7FFFFF, 'h7FFFFF, 'h7FFFFF, 'h7FFFFF);
    send_points('h555555, 'h2AAAAA, 'h2AAAAA, 'h555555);
    send_points('h7FFFFF, 0, 0, 'h7FFFFF);
  endtask

  task automatic test_random(input int count);
    int i;
    int lon, lat;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_points($urandom, $urandom, $urandom, $urandom);
      end else if ($urandom_range(0, 3) == 0) begin
        send_points($urandom_range(0, LON_MAX), $urandom_range(0, COORD_MAX),
                    $urandom_range(0, LON_MAX), $urandom_range(0, COORD_MAX));
      end else begin
        // Nearby points, the usual case.
        lon = $urandom_range(0, LON_MAX - 70000);
        lat = $urandom_range(0, COORD_MAX - 70000);
        send_points(lon, lat, lon + $urandom_range(0, 70000),
                    lat + $urandom_range(0, 70000));
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_random(900);
    calm = 1'b1;
    test_random(200);
    in_tvalid <= 1'b0;
    while (expected_dist.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
